@@ hw/rtl/jsu_pkg.sv @@
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and codes for the JSON string unescaper: the input item and
// result layouts, result kinds, error numbers, parser phases and the command
// format that passes from the parser front end to the UTF-8 back end.
// ----------------------------------------------------------------------------
package jsu_pkg;

	// One source byte, or the end-of-input marker.
	typedef struct packed {
		logic [7:0] in_byte;
		logic       input_end;
	} in_item_t;

	// One result: data byte, string close or error.
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic [3:0] error_code;
		logic       last;
	} result_t;

	// Result kinds.
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// Error numbers.
	localparam logic [3:0] ERR_NONE         = 4'd0;
	localparam logic [3:0] ERR_NO_QUOTE     = 4'd1;
	localparam logic [3:0] ERR_CONTROL      = 4'd2;
	localparam logic [3:0] ERR_BAD_ESCAPE   = 4'd3;
	localparam logic [3:0] ERR_BAD_HEX      = 4'd4;
	localparam logic [3:0] ERR_MISSING_PAIR = 4'd5;
	localparam logic [3:0] ERR_BAD_LOW      = 4'd6;
	localparam logic [3:0] ERR_LONE_LOW     = 4'd7;
	localparam logic [3:0] ERR_END_ESCAPE   = 4'd8;
	localparam logic [3:0] ERR_UNTERMINATED = 4'd9;

	// Parser phases.
	typedef enum logic [2:0] {
		PH_WAIT    = 3'd0,
		PH_BODY    = 3'd1,
		PH_ESC     = 3'd2,
		PH_HEX1    = 3'd3,
		PH_PAIR_BS = 3'd4,
		PH_PAIR_U  = 3'd5,
		PH_HEX2    = 3'd6
	} phase_t;

	// Command operations handed from the front end to the back end.
	typedef enum logic [1:0] {
		OP_BYTE       = 2'd0,
		OP_CODE_POINT = 2'd1,
		OP_END        = 2'd2,
		OP_ERROR      = 2'd3
	} cmd_op_t;

	// One command: all results caused by one input item.
	typedef struct packed {
		cmd_op_t     op;
		logic [20:0] value;
		logic [3:0]  err;
	} cmd_t;

endpackage

@@ hw/rtl/json_string_unescape_utf8_core.sv @@
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_core
// Streaming JSON string unescaper producing UTF-8 bytes, close markers and
// numbered errors.
//
//   channel   handshake        payload     direction
//   input     push / full      item        into the block
//   result    pop / empty      result      out of the block
//
// One source byte is taken per cycle while the command queue has room.
// A code point leaves as one to four result requests set by the UTF-8 expander,
// one per cycle while results are popped; a byte request passes the queue and
// the output stage. Reset returns the parser to waiting for an opening quote
// and empties the queue and output stage. A stalled result side fills the queue
// (QUEUE_DEPTH commands plus one result), then full holds the input side.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_core import jsu_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_item_t item,
	output logic     empty,
	input  logic     pop,
	output result_t  result
);

	logic accept;
	logic cmd_valid;
	cmd_t cmd;
	logic head_valid;
	cmd_t head;
	logic head_pop;

	assign accept = push && !full;

	// Byte classification and escape tracking.
	jsu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd       (cmd)
	);

	// Command queue between the two halves.
	jsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (cmd_valid),
		.push_data  (cmd),
		.full       (full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (head_pop)
	);

	// UTF-8 expansion and output stage.
	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop),
		.result     (result),
		.empty      (empty),
		.pop        (pop)
	);

endmodule

@@ hw/rtl/jsu_front.sv @@
// ----------------------------------------------------------------------------
// jsu_front
// Parser front end. Classifies each accepted byte against the current phase,
// tracks escape and surrogate state, and issues at most one command per byte.
// ----------------------------------------------------------------------------
module jsu_front import jsu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  in_item_t item,
	output logic     cmd_valid,
	output cmd_t     cmd
);

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LOW_B  = 8'h62;
	localparam logic [7:0] CH_LOW_F  = 8'h66;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LOW_R  = 8'h72;
	localparam logic [7:0] CH_LOW_T  = 8'h74;
	localparam logic [7:0] CH_LOW_U  = 8'h75;
	localparam logic [2:0] HEX_LAST  = 3'd3;

	phase_t      phase_q, phase_d;
	logic [1:0]  hex_count_q, hex_count_d;
	logic [11:0] hex_accum_q, hex_accum_d;
	logic [9:0]  high_part_q, high_part_d;

	logic [7:0]  b;
	logic        hex_ok;
	logic [3:0]  hex_val;
	logic [15:0] v;
	logic [20:0] cp_pair;
	logic        emit;
	logic        fail;
	logic [3:0]  fail_code;
	cmd_t        cmd_c;

	assign b = item.in_byte;

	// Hex digit decode.
	always_comb begin
		hex_ok  = 1'b1;
		hex_val = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			hex_val = 4'(b - 8'h30);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			hex_val = 4'(b - 8'h57);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			hex_val = 4'(b - 8'h37);
		end else begin
			hex_ok = 1'b0;
		end
	end

	assign v       = {hex_accum_q, hex_val};
	assign cp_pair = 21'h10000 + {1'b0, high_part_q, v[9:0]};

	// Phase transitions and command selection.
	always_comb begin
		phase_d     = phase_q;
		hex_count_d = hex_count_q;
		hex_accum_d = hex_accum_q;
		high_part_d = high_part_q;
		emit        = 1'b0;
		fail        = 1'b0;
		fail_code   = ERR_NONE;
		cmd_c       = '{op: OP_BYTE, value: '0, err: ERR_NONE};
		unique case (phase_q) inside
			PH_BODY: begin
				if (item.input_end) begin
					fail = 1'b1; fail_code = ERR_UNTERMINATED;
				end else if (b == CH_QUOTE) begin
					phase_d = PH_WAIT;
					emit = 1'b1; cmd_c.op = OP_END;
				end else if (b < CH_SPACE) begin
					fail = 1'b1; fail_code = ERR_CONTROL;
				end else if (b == CH_BSLASH) begin
					phase_d = PH_ESC;
				end else begin
					emit = 1'b1; cmd_c.value = {13'd0, b};
				end
			end
			PH_ESC: begin
				if (item.input_end) begin
					fail = 1'b1; fail_code = ERR_END_ESCAPE;
				end else begin
					phase_d = PH_BODY;
					unique case (b) inside
						CH_QUOTE, CH_BSLASH, CH_SLASH: begin
							emit = 1'b1; cmd_c.value = {13'd0, b};
						end
						CH_LOW_B: begin emit = 1'b1; cmd_c.value = 21'h08; end
						CH_LOW_F: begin emit = 1'b1; cmd_c.value = 21'h0C; end
						CH_LOW_N: begin emit = 1'b1; cmd_c.value = 21'h0A; end
						CH_LOW_R: begin emit = 1'b1; cmd_c.value = 21'h0D; end
						CH_LOW_T: begin emit = 1'b1; cmd_c.value = 21'h09; end
						CH_LOW_U: begin
							phase_d     = PH_HEX1;
							hex_count_d = 2'd0;
							hex_accum_d = 12'd0;
						end
						default: begin
							fail = 1'b1; fail_code = ERR_BAD_ESCAPE;
						end
					endcase
				end
			end
			PH_HEX1, PH_HEX2: begin
				if (item.input_end) begin
					fail = 1'b1; fail_code = ERR_END_ESCAPE;
				end else if (!hex_ok) begin
					fail = 1'b1; fail_code = ERR_BAD_HEX;
				end else if ({1'b0, hex_count_q} != HEX_LAST) begin
					hex_accum_d = v[11:0];
					hex_count_d = hex_count_q + 2'd1;
				end else begin
					hex_count_d = 2'd0;
					hex_accum_d = 12'd0;
					if (phase_q == PH_HEX1) begin
						if (v[15:10] == 6'b110110) begin
							high_part_d = v[9:0];
							phase_d     = PH_PAIR_BS;
						end else if (v[15:10] == 6'b110111) begin
							fail = 1'b1; fail_code = ERR_LONE_LOW;
						end else begin
							phase_d = PH_BODY;
							emit = 1'b1; cmd_c.op = OP_CODE_POINT;
							cmd_c.value = {5'd0, v};
						end
					end else if (v[15:10] != 6'b110111) begin
						fail = 1'b1; fail_code = ERR_BAD_LOW;
					end else begin
						high_part_d = 10'd0;
						phase_d     = PH_BODY;
						emit = 1'b1; cmd_c.op = OP_CODE_POINT;
						cmd_c.value = cp_pair;
					end
				end
			end
			PH_PAIR_BS: begin
				if (item.input_end) begin
					fail = 1'b1; fail_code = ERR_END_ESCAPE;
				end else if (b != CH_BSLASH) begin
					fail = 1'b1; fail_code = ERR_MISSING_PAIR;
				end else begin
					phase_d = PH_PAIR_U;
				end
			end
			PH_PAIR_U: begin
				if (item.input_end) begin
					fail = 1'b1; fail_code = ERR_END_ESCAPE;
				end else if (b != CH_LOW_U) begin
					fail = 1'b1; fail_code = ERR_MISSING_PAIR;
				end else begin
					phase_d     = PH_HEX2;
					hex_count_d = 2'd0;
					hex_accum_d = 12'd0;
				end
			end
			default: begin
				// Waiting: skip whitespace, then require the opening quote.
				phase_d = PH_WAIT;
				if (item.input_end) begin
					fail = 1'b1; fail_code = ERR_NO_QUOTE;
				end else if (b == CH_SPACE || (b >= 8'h09 && b <= 8'h0D)) begin
					phase_d = PH_WAIT;
				end else if (b != CH_QUOTE) begin
					fail = 1'b1; fail_code = ERR_NO_QUOTE;
				end else begin
					phase_d = PH_BODY;
				end
			end
		endcase
		// Any fault resets the parser and reports one error.
		if (fail) begin
			phase_d     = PH_WAIT;
			hex_count_d = 2'd0;
			hex_accum_d = 12'd0;
			high_part_d = 10'd0;
			emit        = 1'b1;
			cmd_c       = '{op: OP_ERROR, value: '0, err: fail_code};
		end
	end

	assign cmd_valid = accept && emit;
	assign cmd       = cmd_c;

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_WAIT;
			hex_count_q <= 2'd0;
			hex_accum_q <= 12'd0;
			high_part_q <= 10'd0;
		end else if (accept) begin
			phase_q     <= phase_d;
			hex_count_q <= hex_count_d;
			hex_accum_q <= hex_accum_d;
			high_part_q <= high_part_d;
		end
	end

	// An error always returns the parser to waiting for a new string.
	a_err_to_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd.op == OP_ERROR |=> phase_q == PH_WAIT)
		else $error("parser not waiting after an error");

	// Hex digits are only counted inside a unicode escape.
	a_hex_phase: assert property (@(posedge clk) disable iff (!arst_n)
		hex_count_q != 2'd0 |-> (phase_q == PH_HEX1 || phase_q == PH_HEX2))
		else $error("hex digit count outside a unicode escape");

endmodule

@@ hw/rtl/jsu_queue.sv @@
// ----------------------------------------------------------------------------
// jsu_queue
// Small command queue between the parser and the UTF-8 back end, so that a
// multi-byte code point drains while the parser keeps taking bytes.
// ----------------------------------------------------------------------------
module jsu_queue import jsu_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	output logic head_valid,
	output cmd_t head,
	input  logic pop
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	// Storage write.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/jsu_back.sv @@
// ----------------------------------------------------------------------------
// jsu_back
// UTF-8 back end. Expands the command at the queue head into one to four
// result requests for a registered output stage, one per cycle unless it stalls.
// ----------------------------------------------------------------------------
module jsu_back import jsu_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    head_valid,
	input  cmd_t    head,
	output logic    head_pop,
	output result_t result,
	output logic    empty,
	input  logic    pop
);

	logic [1:0]  idx_q;
	logic [1:0]  len_m1;
	logic        load;
	logic        out_valid_q;
	result_t     result_q;
	result_t     next_res;
	logic [20:0] cp;

	assign cp = head.value;

	// Number of bytes in this command, minus one.
	always_comb begin
		len_m1 = 2'd0;
		if (head.op == OP_CODE_POINT) begin
			if (cp <= 21'h7F) begin
				len_m1 = 2'd0;
			end else if (cp <= 21'h7FF) begin
				len_m1 = 2'd1;
			end else if (cp <= 21'hFFFF) begin
				len_m1 = 2'd2;
			end else begin
				len_m1 = 2'd3;
			end
		end
	end

	// Select the result for the current byte position.
	always_comb begin
		next_res = '{kind: KIND_DATA, out_byte: 8'd0, error_code: ERR_NONE,
			last: (idx_q == len_m1)};
		unique case (head.op)
			OP_BYTE: next_res.out_byte = cp[7:0];
			OP_END: next_res.kind = KIND_END;
			OP_ERROR: begin
				next_res.kind       = KIND_ERROR;
				next_res.error_code = head.err;
			end
			OP_CODE_POINT: begin
				unique case (len_m1)
					2'd0: next_res.out_byte = cp[7:0];
					2'd1: next_res.out_byte = (idx_q == 2'd0) ?
						{3'b110, cp[10:6]} : {2'b10, cp[5:0]};
					2'd2: begin
						case (idx_q)
							2'd0:    next_res.out_byte = {4'b1110, cp[15:12]};
							2'd1:    next_res.out_byte = {2'b10, cp[11:6]};
							default: next_res.out_byte = {2'b10, cp[5:0]};
						endcase
					end
					default: begin
						case (idx_q)
							2'd0:    next_res.out_byte = {5'b11110, cp[20:18]};
							2'd1:    next_res.out_byte = {2'b10, cp[17:12]};
							2'd2:    next_res.out_byte = {2'b10, cp[11:6]};
							default: next_res.out_byte = {2'b10, cp[5:0]};
						endcase
					end
				endcase
			end
			default: next_res.kind = KIND_DATA;
		endcase
	end

	assign load     = head_valid && (!out_valid_q || pop);
	assign head_pop = load && (idx_q == len_m1);
	assign empty    = !out_valid_q;
	assign result   = result_q;

	// Byte position within the head command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (load) begin
			idx_q <= head_pop ? 2'd0 : idx_q + 2'd1;
		end
	end

	// Output stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output stage payload.
	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= next_res;
		end
	end

	// A code point in progress keeps its command at the queue head.
	a_idx_head: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 2'd0 |-> head_valid)
		else $error("byte position set without a queued command");

	// Close and error results are single and therefore final.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.kind != KIND_DATA |-> result_q.last)
		else $error("close or error result not marked last");

	// An error result always carries a number.
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.kind == KIND_ERROR |-> result_q.error_code != ERR_NONE)
		else $error("error result without an error number");

endmodule

@@ sim/json_string_unescape_utf8_core_test.sv @@
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_core_test
// Self-checking bench for the JSON string unescaper. A short table of source
// bytes exercises the field extremes and most error numbers, then random
// strings follow: mostly well-formed quoted strings with plain bytes, simple
// escapes, \u escapes and surrogate pairs, ended by a closing quote or by one
// injected fault. A behavioral decoder predicts the UTF-8 byte stream, and
// every popped result is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_core_test;
	import jsu_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Run length and limits.
	localparam int unsigned RANDOM_ITEMS = 310;
	localparam int unsigned CYCLE_LIMIT  = 100000;
	localparam int unsigned DRAIN_CYCLES = 32;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned HOLD_AFTER   = 60;
	localparam int unsigned REPORT_MAX   = 10;

	// Source characters with a meaning to the decoder.
	localparam logic [7:0] QUOTE     = 8'h22;
	localparam logic [7:0] BACKSLASH = 8'h5C;
	localparam logic [7:0] SLASH     = 8'h2F;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;

	// Surrogate ranges.
	localparam logic [15:0] HIGH_FIRST = 16'hD800;
	localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
	localparam logic [15:0] LOW_FIRST  = 16'hDC00;
	localparam logic [15:0] LOW_LAST   = 16'hDFFF;

	// One source request, with an optional hand-written expected result.
	typedef struct packed {
		in_item_t item;
		logic     hand;
		result_t  want;
	} stim_row_t;

	typedef enum {DRAIN_FULL, DRAIN_HALF, DRAIN_SLOW, DRAIN_TOGGLE} drain_style_t;

	logic     clk;
	logic     arst_n = 1'b0;
	logic     push   = 1'b0;
	logic     full;
	in_item_t item   = '0;
	logic     empty;
	logic     pop    = 1'b0;
	result_t  result;

	// Directed table: field extremes, whitespace, escapes and most error numbers.
	stim_row_t directed_rows [29] = '{
		'{'{8'h0D, 1'b0}, 1'b0, '0},
		'{'{8'h41, 1'b0}, 1'b1, '{KIND_ERROR, 8'h00, ERR_NO_QUOTE, 1'b1}},
		'{'{8'hFF, 1'b1}, 1'b1, '{KIND_ERROR, 8'h00, ERR_NO_QUOTE, 1'b1}},
		'{'{QUOTE, 1'b0}, 1'b0, '0},
		'{'{8'h1F, 1'b0}, 1'b1, '{KIND_ERROR, 8'h00, ERR_CONTROL, 1'b1}},
		'{'{QUOTE, 1'b0}, 1'b0, '0},
		'{'{8'hFF, 1'b0}, 1'b1, '{KIND_DATA, 8'hFF, ERR_NONE, 1'b1}},
		'{'{8'h20, 1'b0}, 1'b1, '{KIND_DATA, 8'h20, ERR_NONE, 1'b1}},
		'{'{BACKSLASH, 1'b0}, 1'b0, '0},
		'{'{SLASH, 1'b0}, 1'b1, '{KIND_DATA, SLASH, ERR_NONE, 1'b1}},
		'{'{BACKSLASH, 1'b0}, 1'b0, '0},
		'{'{CH_U, 1'b0}, 1'b0, '0},
		'{'{8'h30, 1'b0}, 1'b0, '0},
		'{'{8'h30, 1'b0}, 1'b0, '0},
		'{'{8'h65, 1'b0}, 1'b0, '0},
		'{'{8'h39, 1'b0}, 1'b0, '0},
		'{'{BACKSLASH, 1'b0}, 1'b0, '0},
		'{'{8'h7A, 1'b0}, 1'b1, '{KIND_ERROR, 8'h00, ERR_BAD_ESCAPE, 1'b1}},
		'{'{QUOTE, 1'b0}, 1'b0, '0},
		'{'{8'h00, 1'b1}, 1'b1, '{KIND_ERROR, 8'h00, ERR_UNTERMINATED, 1'b1}},
		'{'{QUOTE, 1'b0}, 1'b0, '0},
		'{'{BACKSLASH, 1'b0}, 1'b0, '0},
		'{'{8'h00, 1'b1}, 1'b1, '{KIND_ERROR, 8'h00, ERR_END_ESCAPE, 1'b1}},
		'{'{QUOTE, 1'b0}, 1'b0, '0},
		'{'{BACKSLASH, 1'b0}, 1'b0, '0},
		'{'{CH_U, 1'b0}, 1'b0, '0},
		'{'{8'h67, 1'b0}, 1'b1, '{KIND_ERROR, 8'h00, ERR_BAD_HEX, 1'b1}},
		'{'{QUOTE, 1'b0}, 1'b0, '0},
		'{'{QUOTE, 1'b0}, 1'b1, '{KIND_END, 8'h00, ERR_NONE, 1'b1}}
	};

	// Source requests still to send, and results still to arrive.
	stim_row_t   send_q [$];
	result_t     expected_q [$];
	result_t     step_results [$];
	int unsigned send_idx     = 0;
	int unsigned random_items = 0;
	int unsigned fault_count  = 0;
	int unsigned cycle_count  = 0;

	// Decoder state mirrored by the bench.
	phase_t      parse_phase = PH_WAIT;
	logic [1:0]  hex_cnt     = '0;
	logic [15:0] hex_val     = '0;
	logic [9:0]  high_bits   = '0;

	// Traffic shaping.
	int unsigned  burst_left  = 8;
	int unsigned  gap_left    = 0;
	int unsigned  style_left  = 0;
	drain_style_t drain_style = DRAIN_FULL;
	logic         hold_off    = 1'b0;

	json_string_unescape_utf8_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Hex digit value, or -1 for any other byte.
	function automatic int nibble_of(input logic [7:0] b);
		if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
		if (b >= 8'h61 && b <= 8'h66) return int'(b - 8'h61) + 10;
		if (b >= 8'h41 && b <= 8'h46) return int'(b - 8'h41) + 10;
		return -1;
	endfunction

	// ------------------------------------------------------------------
	// Decoder prediction
	// ------------------------------------------------------------------

	task automatic add_result(input logic [1:0] kind, input logic [7:0] b,
			input logic [3:0] code);
		result_t r;
		r.kind       = kind;
		r.out_byte   = b;
		r.error_code = code;
		r.last       = 1'b0;
		step_results.insert(step_results.size(), r);
	endtask

	// Any fault drops the string and returns to waiting.
	task automatic fail_with(input logic [3:0] code);
		parse_phase = PH_WAIT;
		hex_cnt     = '0;
		hex_val     = '0;
		high_bits   = '0;
		add_result(KIND_ERROR, 8'h00, code);
	endtask

	task automatic add_utf8(input logic [20:0] cp);
		if (cp <= 21'h7F) begin
			add_result(KIND_DATA, cp[7:0], ERR_NONE);
		end else if (cp <= 21'h7FF) begin
			add_result(KIND_DATA, 8'hC0 | {3'b0, cp[10:6]}, ERR_NONE);
			add_result(KIND_DATA, 8'h80 | {2'b0, cp[5:0]}, ERR_NONE);
		end else if (cp <= 21'hFFFF) begin
			add_result(KIND_DATA, 8'hE0 | {4'b0, cp[15:12]}, ERR_NONE);
			add_result(KIND_DATA, 8'h80 | {2'b0, cp[11:6]}, ERR_NONE);
			add_result(KIND_DATA, 8'h80 | {2'b0, cp[5:0]}, ERR_NONE);
		end else begin
			add_result(KIND_DATA, 8'hF0 | {5'b0, cp[20:18]}, ERR_NONE);
			add_result(KIND_DATA, 8'h80 | {2'b0, cp[17:12]}, ERR_NONE);
			add_result(KIND_DATA, 8'h80 | {2'b0, cp[11:6]}, ERR_NONE);
			add_result(KIND_DATA, 8'h80 | {2'b0, cp[5:0]}, ERR_NONE);
		end
	endtask

	// Advance the mirrored decoder by one source request; results land in step_results.
	task automatic decode_step(input in_item_t it);
		int          nib;
		logic [15:0] v;
		logic [7:0]  b;
		b = it.in_byte;
		nib = nibble_of(b);
		step_results.delete();
		case (parse_phase)
			PH_BODY: begin
				if (it.input_end) fail_with(ERR_UNTERMINATED);
				else if (b == QUOTE) begin
					parse_phase = PH_WAIT;
					add_result(KIND_END, 8'h00, ERR_NONE);
				end else if (b < 8'h20) fail_with(ERR_CONTROL);
				else if (b == BACKSLASH) parse_phase = PH_ESC;
				else add_result(KIND_DATA, b, ERR_NONE);
			end
			PH_ESC: begin
				if (it.input_end) fail_with(ERR_END_ESCAPE);
				else begin
					parse_phase = PH_BODY;
					case (b)
						QUOTE, BACKSLASH, SLASH: add_result(KIND_DATA, b, ERR_NONE);
						CH_B: add_result(KIND_DATA, 8'h08, ERR_NONE);
						CH_F: add_result(KIND_DATA, 8'h0C, ERR_NONE);
						CH_N: add_result(KIND_DATA, 8'h0A, ERR_NONE);
						CH_R: add_result(KIND_DATA, 8'h0D, ERR_NONE);
						CH_T: add_result(KIND_DATA, 8'h09, ERR_NONE);
						CH_U: begin
							parse_phase = PH_HEX1;
							hex_cnt = '0;
							hex_val = '0;
						end
						default: fail_with(ERR_BAD_ESCAPE);
					endcase
				end
			end
			PH_HEX1, PH_HEX2: begin
				if (it.input_end) fail_with(ERR_END_ESCAPE);
				else if (nib < 0) fail_with(ERR_BAD_HEX);
				else begin
					v = {hex_val[11:0], nib[3:0]};
					if (hex_cnt != 2'd3) begin
						hex_val = v;
						hex_cnt = hex_cnt + 2'd1;
					end else begin
						hex_cnt = '0;
						hex_val = '0;
						if (parse_phase == PH_HEX1) begin
							// First escape: hold a high surrogate, refuse a lone low one.
							if (v >= HIGH_FIRST && v <= HIGH_LAST) begin
								high_bits = v[9:0];
								parse_phase = PH_PAIR_BS;
							end else if (v >= LOW_FIRST && v <= LOW_LAST) begin
								fail_with(ERR_LONE_LOW);
							end else begin
								parse_phase = PH_BODY;
								add_utf8({5'b0, v});
							end
						end else if (v < LOW_FIRST || v > LOW_LAST) begin
							fail_with(ERR_BAD_LOW);
						end else begin
							add_utf8(21'h10000 + {1'b0, high_bits, 10'b0} + {11'b0, v[9:0]});
							high_bits = '0;
							parse_phase = PH_BODY;
						end
					end
				end
			end
			PH_PAIR_BS: begin
				if (it.input_end) fail_with(ERR_END_ESCAPE);
				else if (b != BACKSLASH) fail_with(ERR_MISSING_PAIR);
				else parse_phase = PH_PAIR_U;
			end
			PH_PAIR_U: begin
				if (it.input_end) fail_with(ERR_END_ESCAPE);
				else if (b != CH_U) fail_with(ERR_MISSING_PAIR);
				else begin
					parse_phase = PH_HEX2;
					hex_cnt = '0;
					hex_val = '0;
				end
			end
			default: begin
				// Waiting: skip whitespace, demand an opening quote.
				parse_phase = PH_WAIT;
				if (it.input_end) fail_with(ERR_NO_QUOTE);
				else if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D)) ;
				else if (b != QUOTE) fail_with(ERR_NO_QUOTE);
				else parse_phase = PH_BODY;
			end
		endcase
		if (step_results.size() != 0) begin
			step_results[step_results.size() - 1].last = 1'b1;
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus construction
	// ------------------------------------------------------------------

	task automatic queue_item(input logic [7:0] b, input logic at_end, input bit counted);
		stim_row_t row;
		row.item.in_byte   = b;
		row.item.input_end = at_end;
		row.hand           = 1'b0;
		row.want           = '0;
		send_q.insert(send_q.size(), row);
		if (counted) random_items++;
	endtask

	task automatic queue_byte(input logic [7:0] b);
		queue_item(b, 1'b0, 1'b1);
	endtask

	task automatic queue_end();
		queue_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
	endtask

	// Hex character for a nibble, letters in either case.
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) return 8'h30 + {4'b0, n};
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'b0, n} - 8'd10;
	endfunction

	task automatic queue_partial_hex(input int unsigned digits);
		int unsigned k;
		queue_byte(BACKSLASH);
		queue_byte(CH_U);
		for (k = 0; k < digits; k++) queue_byte(hex_char(4'($urandom_range(0, 15))));
	endtask

	task automatic queue_unicode(input logic [15:0] v);
		int k;
		queue_byte(BACKSLASH);
		queue_byte(CH_U);
		for (k = 3; k >= 0; k--) queue_byte(hex_char(v[4 * k +: 4]));
	endtask

	function automatic logic [15:0] high_unit();
		case ($urandom_range(0, 3))
			0: return HIGH_FIRST;
			1: return HIGH_LAST;
			default: return HIGH_FIRST + 16'($urandom_range(0, 'h3FF));
		endcase
	endfunction

	function automatic logic [15:0] low_unit();
		case ($urandom_range(0, 3))
			0: return LOW_FIRST;
			1: return LOW_LAST;
			default: return LOW_FIRST + 16'($urandom_range(0, 'h3FF));
		endcase
	endfunction

	// Non-surrogate value, spread over the one, two and three byte encodings.
	function automatic logic [15:0] plane0_value();
		logic [15:0] edges [8];
		edges = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
			16'h0800, 16'hD7FF, 16'hE000, 16'hFFFF};
		case ($urandom_range(0, 4))
			0: return 16'($urandom_range(0, 'h7F));
			1: return 16'($urandom_range('h80, 'h7FF));
			2: return 16'($urandom_range('h800, 'hD7FF));
			3: return 16'($urandom_range('hE000, 'hFFFF));
			default: return edges[$urandom_range(0, 7)];
		endcase
	endfunction

	function automatic logic [7:0] escape_letter();
		case ($urandom_range(0, 7))
			0: return QUOTE;
			1: return BACKSLASH;
			2: return SLASH;
			3: return CH_B;
			4: return CH_F;
			5: return CH_N;
			6: return CH_R;
			default: return CH_T;
		endcase
	endfunction

	function automatic bit is_escape_letter(input logic [7:0] b);
		case (b)
			QUOTE, BACKSLASH, SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// One random string: mostly well formed, sometimes noise or cut short by a fault.
	task automatic queue_random_string();
		int unsigned k;
		int unsigned segments;
		logic [15:0] v;
		logic [7:0]  b;
		logic [7:0]  blanks [6];
		blanks = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

		// Leading whitespace is skipped by the block and not counted.
		for (k = $urandom_range(0, 2); k > 0; k--)
			queue_item(blanks[$urandom_range(0, 5)], 1'b0, 1'b0);

		// Noise outside any string.
		if ($urandom_range(0, 11) == 0) begin
			for (k = $urandom_range(1, 3); k > 0; k--) begin
				case ($urandom_range(0, 2))
					0: queue_end();
					1: begin
						do b = 8'($urandom_range(0, 255));
						while (b == QUOTE || b == 8'h20 || (b >= 8'h09 && b <= 8'h0D));
						queue_byte(b);
					end
					default: queue_item(blanks[$urandom_range(0, 5)], 1'b0, 1'b0);
				endcase
			end
			return;
		end

		queue_byte(QUOTE);
		segments = $urandom_range(0, 6);
		for (k = 0; k < segments; k++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					do b = 8'($urandom_range('h20, 'hFF));
					while (b == QUOTE || b == BACKSLASH);
					queue_byte(b);
				end
				4, 5: begin
					queue_byte(BACKSLASH);
					queue_byte(escape_letter());
				end
				6, 7: queue_unicode(plane0_value());
				default: begin
					queue_unicode(high_unit());
					queue_unicode(low_unit());
				end
			endcase
		end

		// Close the string, or end it with one fault.
		if ($urandom_range(0, 2) != 0) begin
			queue_byte(QUOTE);
			return;
		end
		case ($urandom_range(0, 9))
			0: queue_byte(8'($urandom_range(0, 'h1F)));
			1: begin
				queue_byte(BACKSLASH);
				do b = 8'($urandom_range(0, 255));
				while (is_escape_letter(b));
				queue_byte(b);
			end
			2: begin
				queue_partial_hex($urandom_range(0, 3));
				do b = 8'($urandom_range(0, 255));
				while (nibble_of(b) >= 0);
				queue_byte(b);
			end
			3: begin
				queue_unicode(high_unit());
				if ($urandom_range(0, 1)) begin
					do b = 8'($urandom_range(0, 255));
					while (b == BACKSLASH);
					queue_byte(b);
				end else begin
					queue_byte(BACKSLASH);
					do b = 8'($urandom_range(0, 255));
					while (b == CH_U);
					queue_byte(b);
				end
			end
			4: begin
				queue_unicode(high_unit());
				do v = 16'($urandom_range(0, 'hFFFF));
				while (v >= LOW_FIRST && v <= LOW_LAST);
				queue_unicode(v);
			end
			5: queue_unicode(low_unit());
			6: queue_end();
			7: begin
				queue_byte(BACKSLASH);
				queue_end();
			end
			8: begin
				queue_partial_hex($urandom_range(0, 3));
				queue_end();
			end
			default: begin
				queue_unicode(high_unit());
				case ($urandom_range(0, 2))
					0: ;
					1: queue_byte(BACKSLASH);
					default: queue_partial_hex($urandom_range(0, 3));
				endcase
				queue_end();
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic note_fault(input string what, input result_t want, input result_t got);
		if (fault_count < REPORT_MAX) begin
			$write("cycle %0d: %s: expected kind=%0d byte=%02h err=%0d last=%0d, ",
				cycle_count, what, want.kind, want.out_byte, want.error_code, want.last);
			$display("got kind=%0d byte=%02h err=%0d last=%0d",
				got.kind, got.out_byte, got.error_code, got.last);
		end
		fault_count++;
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (expected_q.size() == 0) begin
			note_fault("result with none pending", '0, got);
			return;
		end
		want = expected_q.pop_front();
		if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
				got.error_code !== want.error_code || got.last !== want.last)
			note_fault("result mismatch", want, got);
	endtask

	// Record an accepted request: hand-written rows give their own expectation.
	task automatic accept_row(input stim_row_t row);
		decode_step(row.item);
		if (row.hand) expected_q.insert(expected_q.size(), row.want);
		else foreach (step_results[i]) expected_q.insert(expected_q.size(), step_results[i]);
	endtask

	// ------------------------------------------------------------------
	// Source side: bursts of requests with random gaps.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : feed
		if (push && !full) begin
			accept_row(send_q[send_idx]);
			send_idx++;
			if (burst_left != 0) burst_left--;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			end
		end
		if (!arst_n) begin
			push <= 1'b0;
		end else if (push && full) begin
			// Keep offering the same request until it is taken.
		end else if (send_idx >= send_q.size()) begin
			push <= 1'b0;
		end else if (gap_left != 0) begin
			push <= 1'b0;
			gap_left--;
		end else begin
			push <= 1'b1;
			item <= send_q[send_idx].item;
		end
	end

	// ------------------------------------------------------------------
	// Result side: the drain style is redrawn whenever its run ends.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : drain
		if (pop && !empty) check_result(result);
		if (style_left == 0) begin
			drain_style = drain_style_t'($urandom_range(0, 3));
			style_left = $urandom_range(40, 120);
		end else begin
			style_left--;
		end
		if (!arst_n || hold_off) begin
			pop <= 1'b0;
		end else begin
			case (drain_style)
				DRAIN_FULL: pop <= 1'b1;
				DRAIN_HALF: pop <= 1'($urandom_range(0, 1));
				DRAIN_SLOW: pop <= ($urandom_range(0, 3) == 0);
				default: pop <= ~pop;
			endcase
		end
	end

	// One long stall of the result side so the block fills and holds its input.
	initial begin : long_stall
		wait (send_idx >= HOLD_AFTER);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Watchdog.
	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Build the stimulus, release reset, wait for the traffic to drain.
	initial begin : run
		int unsigned i;
		for (i = 0; i < $size(directed_rows); i++)
			send_q.insert(send_q.size(), directed_rows[i]);
		while (random_items < RANDOM_ITEMS) queue_random_string();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		while (send_idx < send_q.size() || expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

endmodule
